// ===== design/msrs_pkg.sv =====
// Shared types and constants for the motor speed ramp sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package msrs_pkg;

    localparam int SPEED_W = 8;
    localparam int DUTY_W  = 10;
    localparam int HOLD_W  = 8;
    localparam int FRAC_W  = 5;
    localparam int CNT_W   = 3;
    localparam int TGT_W   = 9;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_RAMP_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_BUMP_DUTY      = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUMP_HOLD_MS   = 2'd2;

    localparam logic [SPEED_W-1:0] RST_RAMP_THRESHOLD = 8'd50;
    localparam logic [DUTY_W-1:0]  RST_BUMP_DUTY      = 10'd1023;
    localparam logic [HOLD_W-1:0]  RST_BUMP_HOLD_MS   = 8'd10;

    localparam logic [CNT_W-1:0] RAMP_FIRST = 3'd1;
    localparam logic [CNT_W-1:0] RAMP_LAST  = 3'd7;
    localparam int STEP_SHIFT = 3;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_DIR0  = 6'b000010,
        PH_DIR1  = 6'b000100,
        PH_BUMP  = 6'b001000,
        PH_RAMP  = 6'b010000,
        PH_FINAL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        dir_t               dir;
        logic               in1;
        logic               in2;
        logic               stby;
    } drive_t;

    typedef struct packed {
        logic               dir_chg;
        logic               bump;
        logic               ramp;
        logic               fin;
        logic               old_in1;
        logic               old_in2;
        logic               old_stby;
        logic [SPEED_W-1:0] start;
        logic [FRAC_W-1:0]  frac;
        logic [SPEED_W-1:0] mag;
    } plan_t;

endpackage
`default_nettype wire

// ===== design/msrs_decode.sv =====
// Command decoder: turns one target speed and the present drive state into a
// setting plan and the drive state that follows. Depends on msrs_pkg.
`default_nettype none
module msrs_decode
    import msrs_pkg::*;
(
    input  wire logic [TGT_W-1:0]   target,
    input  wire drive_t             cur,
    input  wire logic [SPEED_W-1:0] ramp_threshold,
    output plan_t                   plan,
    output drive_t                  nxt
);

    logic [TGT_W-1:0]   neg;
    logic [SPEED_W-1:0] mag;
    dir_t               dir;
    logic [SPEED_W-1:0] start;
    logic [SPEED_W-1:0] diff;
    logic               dir_chg;
    logic               rise;
    logic               fall;

    always_comb begin
        neg = ~target + 9'd1;
        if (target == '0) begin
            dir = DIR_STOP;
            mag = '0;
        end else if (target[TGT_W-1]) begin
            dir = DIR_REV;
            mag = neg[TGT_W-1] ? 8'hFF : neg[SPEED_W-1:0];
        end else begin
            dir = DIR_FWD;
            mag = target[SPEED_W-1:0];
        end

        dir_chg = (dir != cur.dir);
        start   = dir_chg ? '0 : cur.speed;
        rise    = (start < mag);
        fall    = (start > mag);
        diff    = mag - start;

        plan.dir_chg  = dir_chg;
        plan.bump     = rise && (start == '0);
        plan.ramp     = rise && (diff > ramp_threshold);
        plan.fin      = rise || fall;
        plan.old_in1  = cur.in1;
        plan.old_in2  = cur.in2;
        plan.old_stby = cur.stby;
        plan.start    = start;
        plan.frac     = diff[SPEED_W-1:STEP_SHIFT];
        plan.mag      = mag;

        nxt       = cur;
        nxt.dir   = dir;
        nxt.speed = (rise || fall) ? mag : start;
        if (dir_chg) begin
            unique case (dir)
                DIR_FWD: begin
                    nxt.in1  = 1'b0;
                    nxt.in2  = 1'b1;
                    nxt.stby = 1'b1;
                end
                DIR_REV: begin
                    nxt.in1  = 1'b1;
                    nxt.in2  = 1'b0;
                    nxt.stby = 1'b1;
                end
                default: begin
                    nxt.stby = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/msrs_seq.sv =====
// Setting sequencer and output register: walks one plan, one setting a beat.
// Depends on msrs_pkg.
`default_nettype none
module msrs_seq
    import msrs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               plan_valid,
    input  wire plan_t              plan,
    output logic                    plan_take,
    input  wire drive_t             cur,
    input  wire logic [DUTY_W-1:0]  bump_duty,
    input  wire logic [HOLD_W-1:0]  bump_hold_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [DUTY_W-1:0]       m_pwm_duty,
    output logic                    m_pin_in1,
    output logic                    m_pin_in2,
    output logic                    m_standby_on,
    output logic [HOLD_W-1:0]       m_hold_ms,
    output logic                    m_last_setting
);

    phase_t             phase_reg, phase_next, after_phase, first_phase;
    plan_t              plan_reg;
    logic [SPEED_W-1:0] acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               m_valid_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               in1_reg, in2_reg, stby_reg, last_reg;
    logic [HOLD_W-1:0]  hold_reg;

    logic               busy, out_load, is_last;
    logic [SPEED_W-1:0] step_speed;
    logic [DUTY_W-1:0]  duty_d;
    logic               in1_d, in2_d, stby_d;
    logic [HOLD_W-1:0]  hold_d;

    assign busy       = (phase_reg != PH_IDLE);
    assign out_load   = busy && (!m_valid_reg || m_ready);
    assign step_speed = acc_reg + {3'b000, plan_reg.frac};

    always_comb begin
        unique case (phase_reg)
            PH_DIR0:  after_phase = PH_DIR1;
            PH_DIR1:  after_phase = plan_reg.bump ? PH_BUMP :
                                    plan_reg.ramp ? PH_RAMP :
                                    plan_reg.fin  ? PH_FINAL : PH_IDLE;
            PH_BUMP:  after_phase = plan_reg.ramp ? PH_RAMP :
                                    plan_reg.fin  ? PH_FINAL : PH_IDLE;
            PH_RAMP:  after_phase = (cnt_reg == RAMP_LAST) ? PH_FINAL : PH_RAMP;
            default:  after_phase = PH_IDLE;
        endcase

        first_phase = plan.dir_chg ? PH_DIR0 :
                      plan.bump    ? PH_BUMP :
                      plan.ramp    ? PH_RAMP :
                      plan.fin     ? PH_FINAL : PH_IDLE;

        is_last   = (after_phase == PH_IDLE);
        plan_take = plan_valid && (!busy || (is_last && out_load));

        phase_next = phase_reg;
        if (plan_take) begin
            phase_next = first_phase;
        end else if (out_load) begin
            phase_next = after_phase;
        end

        duty_d = '0;
        in1_d  = cur.in1;
        in2_d  = cur.in2;
        stby_d = cur.stby;
        hold_d = '0;
        unique case (phase_reg)
            PH_DIR0: begin
                in1_d  = plan_reg.old_in1;
                in2_d  = plan_reg.old_in2;
                stby_d = plan_reg.old_stby;
            end
            PH_BUMP: begin
                duty_d = bump_duty;
                hold_d = bump_hold_ms;
            end
            PH_RAMP: begin
                duty_d = {step_speed, 2'b00};
                hold_d = {3'b000, plan_reg.frac};
            end
            PH_FINAL: begin
                duty_d = {plan_reg.mag, 2'b00};
            end
            default: begin
                duty_d = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_take) begin
            plan_reg <= plan;
            acc_reg  <= plan.start;
            cnt_reg  <= RAMP_FIRST;
        end else if (out_load && phase_reg == PH_RAMP) begin
            acc_reg <= step_speed;
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (out_load) begin
            duty_reg <= duty_d;
            in1_reg  <= in1_d;
            in2_reg  <= in2_d;
            stby_reg <= stby_d;
            hold_reg <= hold_d;
            last_reg <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pwm_duty     = duty_reg;
    assign m_pin_in1      = in1_reg;
    assign m_pin_in2      = in2_reg;
    assign m_standby_on   = stby_reg;
    assign m_hold_ms      = hold_reg;
    assign m_last_setting = last_reg;

`ifndef ASSERT_OFF
    a_ramp_planned: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RAMP |-> plan_reg.ramp && cnt_reg != '0)
        else $error("ramp phase without a planned ramp");
    a_dir_planned: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DIR0 || phase_reg == PH_DIR1) |-> plan_reg.dir_chg)
        else $error("direction phase without a direction change");
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FINAL && out_load |=> m_last_setting)
        else $error("final setting not marked last");
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        plan_take && busy |-> is_last && out_load)
        else $error("plan taken while settings remain");
`endif

endmodule
`default_nettype wire

// ===== design/motor_speed_ramp_sequencer_core.sv =====
// Top level of the motor speed ramp sequencer: config registers, command
// register, drive state. Depends on msrs_pkg, msrs_decode, msrs_seq.
//
// Usage: each s_ beat carries one signed target speed. The block answers
// with zero to eleven m_ beats of H-bridge settings (duty, in1, in2, standby,
// hold time); m_last_setting marks the final beat of a command. A command
// that repeats the present direction and speed gives no beats.
// An accepted command passes the command register, the sequencer phase
// register and the output register before its first setting is valid; the
// following settings come one per cycle from the single sequencer while
// m_ready is high.
// A command register lets the next command be taken while settings are
// still going out, and the sequencer takes it in the same cycle as it loads
// the last setting of the previous one.
// When m_ready is low the output register holds its beat and the sequencer
// waits; s_ready drops once the command register is full.
// Reset (aresetn low, synchronous) clears the drive state to stopped,
// speed zero, all pins low, and loads the config defaults 50 / 1023 / 10.
// Config writes (cfg_wr_en) take effect at once and belong in idle periods.
`default_nettype none
module motor_speed_ramp_sequencer_core
    import msrs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [TGT_W-1:0]   s_target_speed,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [DUTY_W-1:0]       m_pwm_duty,
    output logic                    m_pin_in1,
    output logic                    m_pin_in2,
    output logic                    m_standby_on,
    output logic [HOLD_W-1:0]       m_hold_ms,
    output logic                    m_last_setting
);

    logic [SPEED_W-1:0] thr_reg;
    logic [DUTY_W-1:0]  bump_duty_reg;
    logic [HOLD_W-1:0]  bump_hold_reg;
    logic               cmd_valid_reg;
    logic [TGT_W-1:0]   cmd_reg;
    drive_t             drive_reg, drive_next;
    plan_t              plan;
    logic               plan_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= RST_RAMP_THRESHOLD;
            bump_duty_reg <= RST_BUMP_DUTY;
            bump_hold_reg <= RST_BUMP_HOLD_MS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RAMP_THRESHOLD: thr_reg       <= cfg_wdata[SPEED_W-1:0];
                REG_BUMP_DUTY:      bump_duty_reg <= cfg_wdata;
                REG_BUMP_HOLD_MS:   bump_hold_reg <= cfg_wdata[HOLD_W-1:0];
                default:            thr_reg       <= thr_reg;
            endcase
        end
    end

    assign s_ready = !cmd_valid_reg || plan_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            drive_reg     <= '{speed: '0, dir: DIR_STOP, in1: 1'b0, in2: 1'b0, stby: 1'b0};
        end else begin
            if (s_valid && s_ready) begin
                cmd_valid_reg <= 1'b1;
            end else if (plan_take) begin
                cmd_valid_reg <= 1'b0;
            end
            if (plan_take) begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_target_speed;
        end
    end

    msrs_decode u_decode (
        .target         (cmd_reg),
        .cur            (drive_reg),
        .ramp_threshold (thr_reg),
        .plan           (plan),
        .nxt            (drive_next)
    );

    msrs_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .plan_valid     (cmd_valid_reg),
        .plan           (plan),
        .plan_take      (plan_take),
        .cur            (drive_reg),
        .bump_duty      (bump_duty_reg),
        .bump_hold_ms   (bump_hold_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_duty     (m_pwm_duty),
        .m_pin_in1      (m_pin_in1),
        .m_pin_in2      (m_pin_in2),
        .m_standby_on   (m_standby_on),
        .m_hold_ms      (m_hold_ms),
        .m_last_setting (m_last_setting)
    );

`ifndef ASSERT_OFF
    a_no_dir3: assert property (@(posedge aclk) disable iff (!aresetn)
        drive_reg.dir == DIR_STOP |-> drive_reg.speed == '0)
        else $error("stopped with nonzero speed");
    a_take_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        plan_take |-> cmd_valid_reg)
        else $error("plan taken without a command");
    a_pins_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(drive_reg.in1 && drive_reg.in2))
        else $error("both bridge inputs high");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for motor_speed_ramp_sequencer_core: a directed command table, then
// random speed commands under several register settings, checked beat by beat.
// Depends on msrs_pkg and the block's RTL only.
module tb_top;
    import msrs_pkg::*;

    localparam int LIMIT       = 250000;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 300;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 49;
    localparam int N_ROWS      = 20;
    localparam int DUTY_SHIFT  = 2;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              in1;
        logic              in2;
        logic              stby;
        logic [HOLD_W-1:0] hold;
        logic              fin;
    } setting_t;

    typedef struct {
        int speed;
        bit typed;
        int n;
        int duty;
    } cmd_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [TGT_W-1:0]   s_target_speed;
    logic               m_valid;
    logic               m_ready;
    logic [DUTY_W-1:0]  m_pwm_duty;
    logic               m_pin_in1;
    logic               m_pin_in2;
    logic               m_standby_on;
    logic [HOLD_W-1:0]  m_hold_ms;
    logic               m_last_setting;

    // bridge model state and register copies
    logic [SPEED_W-1:0] drv_speed;
    dir_t               drv_dir;
    logic               drv_in1, drv_in2, drv_stby;
    logic [SPEED_W-1:0] cfg_thr;
    logic [DUTY_W-1:0]  cfg_bump;
    logic [HOLD_W-1:0]  cfg_bhold;

    setting_t           setting_q[$];
    logic [TGT_W-1:0]   last_tgt;
    bit                 tx_idle, rx_idle, hold_req;
    int                 n_fail, n_beats, n_cmds, cycles;

    const cmd_row_t rows [N_ROWS] = '{
        '{0,    1, 0,  0},
        '{255,  1, 11, 1020},
        '{255,  1, 0,  0},
        '{10,   1, 1,  40},
        '{60,   1, 1,  240},
        '{111,  1, 8,  444},
        '{-256, 1, 11, 1020},
        '{-255, 1, 0,  0},
        '{-1,   1, 1,  4},
        '{1,    1, 4,  4},
        '{0,    1, 2,  0},
        '{0,    1, 0,  0},
        '{-3,   1, 4,  12},
        '{0,    1, 2,  0},
        '{5,    1, 4,  20},
        '{-128, 0, 0,  0},
        '{127,  0, 0,  0},
        '{170,  0, 0,  0},
        '{-85,  0, 0,  0},
        '{-170, 0, 0,  0}
    };

    motor_speed_ramp_sequencer_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_speed (s_target_speed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_duty     (m_pwm_duty),
        .m_pin_in1      (m_pin_in1),
        .m_pin_in2      (m_pin_in2),
        .m_standby_on   (m_standby_on),
        .m_hold_ms      (m_hold_ms),
        .m_last_setting (m_last_setting)
    );

    always #5 aclk = ~aclk;

    function automatic setting_t drive_setting(input int duty, input int hold);
        setting_t s;
        s.duty = DUTY_W'(duty);
        s.in1  = drv_in1;
        s.in2  = drv_in2;
        s.stby = drv_stby;
        s.hold = HOLD_W'(hold);
        s.fin  = 1'b0;
        return s;
    endfunction

    // Bridge settings for one accepted speed command, appended to setting_q.
    task automatic plan_settings(input logic [TGT_W-1:0] tgt, output int count,
                                 output logic [DUTY_W-1:0] fin_duty);
        setting_t burst[$];
        dir_t     want_dir;
        int       mag, start, diff, frac, i;
        if (tgt == '0) begin
            want_dir = DIR_STOP;
            mag = 0;
        end else if (tgt[TGT_W-1]) begin
            want_dir = DIR_REV;
            mag = 512 - int'(tgt);
        end else begin
            want_dir = DIR_FWD;
            mag = int'(tgt);
        end
        if (mag > 255) mag = 255;

        if (want_dir != drv_dir) begin
            burst.push_back(drive_setting(0, 0));
            drv_speed = '0;
            case (want_dir)
                DIR_FWD: begin
                    drv_in1 = 1'b0; drv_in2 = 1'b1; drv_stby = 1'b1;
                end
                DIR_REV: begin
                    drv_in1 = 1'b1; drv_in2 = 1'b0; drv_stby = 1'b1;
                end
                default: drv_stby = 1'b0;
            endcase
            drv_dir = want_dir;
            burst.push_back(drive_setting(0, 0));
        end

        start = int'(drv_speed);
        if (start < mag) begin
            diff = mag - start;
            if (start == 0) burst.push_back(drive_setting(int'(cfg_bump), int'(cfg_bhold)));
            if (diff > int'(cfg_thr)) begin
                frac = diff >> STEP_SHIFT;
                for (i = int'(RAMP_FIRST); i <= int'(RAMP_LAST); i++)
                    burst.push_back(drive_setting((start + frac * i) << DUTY_SHIFT, frac));
            end
            burst.push_back(drive_setting(mag << DUTY_SHIFT, 0));
            drv_speed = SPEED_W'(mag);
        end else if (start > mag) begin
            burst.push_back(drive_setting(mag << DUTY_SHIFT, 0));
            drv_speed = SPEED_W'(mag);
        end

        count = burst.size();
        fin_duty = '0;
        if (count > 0) begin
            burst[count-1].fin = 1'b1;
            fin_duty = burst[count-1].duty;
        end
        foreach (burst[k]) setting_q.push_back(burst[k]);
    endtask

    task automatic send_command(input logic [TGT_W-1:0] tgt, output int count,
                                output logic [DUTY_W-1:0] fin_duty);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_target_speed <= tgt;
        do @(posedge aclk); while (!(s_valid && s_ready));
        last_tgt = tgt;
        n_cmds++;
        plan_settings(tgt, count, fin_duty);
    endtask

    // Stop offering, let every setting come out, then give the sequencer time
    // to finish any command that produced no beat.
    task automatic drain();
        s_valid <= 1'b0;
        while (setting_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_RAMP_THRESHOLD: cfg_thr   = val[SPEED_W-1:0];
            REG_BUMP_DUTY:      cfg_bump  = val;
            REG_BUMP_HOLD_MS:   cfg_bhold = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly same-direction speed changes, with stops, reversals, repeats
    // and raw patterns mixed in.
    function automatic logic [TGT_W-1:0] next_target();
        int r, m;
        bit rev;
        r   = $urandom_range(0, 99);
        m   = $urandom_range(1, 255);
        rev = $urandom_range(0, 1);
        if (r < 8) return last_tgt;
        if (r < 16) return '0;
        if (r < 22) return rev ? TGT_W'(-256) : TGT_W'(255);
        if (r < 34) return TGT_W'($urandom_range(0, 511));
        if (r < 44) rev = (drv_dir != DIR_REV);
        else if (drv_dir != DIR_STOP) rev = (drv_dir == DIR_REV);
        if (r >= 70 && drv_speed != 0) begin
            m = int'(drv_speed) + $urandom_range(0, 20) - 10;
            if (m < 1) m = 1;
            if (m > 255) m = 255;
        end
        return rev ? TGT_W'(-m) : TGT_W'(m);
    endfunction

    // result side: random stalls per beat, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = rx_idle ? $urandom_range(0, 9) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        setting_t got, exp_s;
        if (aresetn && m_valid && m_ready) begin
            got = '{duty: m_pwm_duty, in1: m_pin_in1, in2: m_pin_in2,
                    stby: m_standby_on, hold: m_hold_ms, fin: m_last_setting};
            n_beats++;
            if (setting_q.size() == 0) begin
                $error("unexpected beat: pwm_duty %0d hold_ms %0d", got.duty, got.hold);
                n_fail++;
            end else begin
                exp_s = setting_q.pop_front();
                if (got.duty !== exp_s.duty) begin
                    $error("pwm_duty: expected %0d, got %0d", exp_s.duty, got.duty);
                    n_fail++;
                end
                if (got.in1 !== exp_s.in1) begin
                    $error("pin_in1: expected %0d, got %0d", exp_s.in1, got.in1);
                    n_fail++;
                end
                if (got.in2 !== exp_s.in2) begin
                    $error("pin_in2: expected %0d, got %0d", exp_s.in2, got.in2);
                    n_fail++;
                end
                if (got.stby !== exp_s.stby) begin
                    $error("standby_on: expected %0d, got %0d", exp_s.stby, got.stby);
                    n_fail++;
                end
                if (got.hold !== exp_s.hold) begin
                    $error("hold_ms: expected %0d, got %0d", exp_s.hold, got.hold);
                    n_fail++;
                end
                if (got.fin !== exp_s.fin) begin
                    $error("last_setting: expected %0d, got %0d", exp_s.fin, got.fin);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int                 cnt, p, j;
        logic [DUTY_W-1:0]  fd;
        int                 thr_v   [N_PHASES];
        int                 bump_v  [N_PHASES];
        int                 bhold_v [N_PHASES];

        thr_v   = '{0, 255, 7,   $urandom_range(0, 255),  1,   50};
        bump_v  = '{0, 1023, 512, $urandom_range(0, 1023), 1,   1023};
        bhold_v = '{0, 255, 1,   $urandom_range(0, 255),  128, 10};

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_target_speed <= '0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_RAMP_THRESHOLD;
        cfg_wdata      <= '0;
        n_fail = 0; n_beats = 0; n_cmds = 0; cycles = 0;
        hold_req = 1'b0; tx_idle = 1'b1; rx_idle = 1'b1;
        last_tgt  = '0;
        drv_speed = '0; drv_dir = DIR_STOP;
        drv_in1 = 1'b0; drv_in2 = 1'b0; drv_stby = 1'b0;
        cfg_thr = RST_RAMP_THRESHOLD; cfg_bump = RST_BUMP_DUTY; cfg_bhold = RST_BUMP_HOLD_MS;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) begin
            send_command(TGT_W'(rows[k].speed), cnt, fd);
            if (rows[k].typed && (cnt != rows[k].n || (cnt > 0 && fd != rows[k].duty))) begin
                $error("speed %0d: expected %0d settings ending at duty %0d, model gives %0d / %0d",
                       rows[k].speed, rows[k].n, rows[k].duty, cnt, fd);
                n_fail++;
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            drain();
            write_reg(REG_RAMP_THRESHOLD, {2'($urandom), 8'(thr_v[p])});
            write_reg(REG_BUMP_DUTY, CFG_W'(bump_v[p]));
            write_reg(REG_BUMP_HOLD_MS, {2'($urandom), 8'(bhold_v[p])});
            write_reg(REG_SPARE, CFG_W'($urandom));
            cfg_wr_en <= 1'b0;
            tx_idle = (p % 3) != 1;
            rx_idle = (p % 2) == 0;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                if (p == 1 && j == 10) hold_req = 1'b1;
                if (p == 2 && j == 25) drain();
                send_command(next_target(), cnt, fd);
            end
        end

        drain();
        $display("Ran %0d speed commands (%0d directed) over %0d register settings,",
                 n_cmds, N_ROWS, N_PHASES + 1);
        $display("checking %0d drive settings with random and long output stalls.", n_beats);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
